>>> rtl/cubic_bezier_point_and_derivatives_assert.svh
// Assertion macros for the cubic Bezier evaluator checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef CUBIC_BEZIER_POINT_AND_DERIVATIVES_ASSERT_SVH
`define CUBIC_BEZIER_POINT_AND_DERIVATIVES_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define CBZ_ASSERT_COMB(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define CBZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cbz_pkg.sv
// Shared widths, limits, register indexes and fixed-point helpers for the
// cubic Bezier evaluator. No dependencies.
package cbz_pkg;

  // Field widths
  localparam int CW     = 24;  // control point / curve point
  localparam int TW     = 17;  // curve parameter
  localparam int SW     = 27;  // first derivative
  localparam int BW     = 29;  // second derivative
  localparam int FRAC_T = 16;  // fraction bits of t

  // Internal widths
  localparam int DW   = CW + 1;               // control point difference
  localparam int FW   = DW + TW + 1 - FRAC_T; // first rank of scaled terms
  localparam int QW   = 28;                   // quadratic point, slope, bend
  localparam int MW   = QW + TW + 1 - FRAC_T; // second rank of scaled terms
  localparam int SUMW = 33;                   // final sums before saturation

  // Configuration port
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int NUM_REGS = 8;

  localparam logic [TW-1:0] ONE_T = TW'(65536);

  // Output ranges
  localparam logic signed [SUMW-1:0] POINT_MAX = SUMW'(8388607);
  localparam logic signed [SUMW-1:0] POINT_MIN = SUMW'(-8388608);
  localparam logic signed [SUMW-1:0] SLOPE_MAX = SUMW'(50331647);
  localparam logic signed [SUMW-1:0] SLOPE_MIN = SUMW'(-50331648);
  localparam logic signed [SUMW-1:0] BEND_MAX  = SUMW'(201326591);
  localparam logic signed [SUMW-1:0] BEND_MIN  = SUMW'(-201326592);

  // Axis lanes
  localparam int NUM_AX = 2;
  localparam int AX_X   = 0;
  localparam int AX_Y   = 1;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_PULL_A_X = 3'd2,
    REG_PULL_A_Y = 3'd3,
    REG_PULL_B_X = 3'd4,
    REG_PULL_B_Y = 3'd5,
    REG_END_X    = 3'd6,
    REG_END_Y    = 3'd7
  } cfg_reg_t;

  // floor(v * f / 2^16) on a control point difference
  function automatic logic signed [FW-1:0] fmul_d(input logic signed [DW-1:0] v,
                                                  input logic [TW-1:0] f);
    logic signed [DW+TW:0] p;
    p = v * $signed({1'b0, f});
    return p[DW+TW:FRAC_T];
  endfunction

  // floor(v * f / 2^16) on a quadratic term
  function automatic logic signed [MW-1:0] fmul_q(input logic signed [QW-1:0] v,
                                                  input logic [TW-1:0] f);
    logic signed [QW+TW:0] p;
    p = v * $signed({1'b0, f});
    return p[QW+TW:FRAC_T];
  endfunction

  // Clamp to [lo, hi]
  function automatic logic signed [SUMW-1:0] sat(input logic signed [SUMW-1:0] v,
                                                 input logic signed [SUMW-1:0] lo,
                                                 input logic signed [SUMW-1:0] hi);
    logic signed [SUMW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

>>> rtl/cubic_bezier_point_and_derivatives.sv
// Pipelined planar cubic Bezier evaluator: point, slope and bend per t.
// Depends on cbz_pkg.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------
//   in_      | in        | in_valid/in_stall  | in_param_t
//   out_     | out       | out_valid/out_stall| point, slope, bend in x and y
//   config   | in        | APB psel/penable   | eight 24-bit control coordinates
//
// One transaction per cycle when not stalled; each passes clamp and square
// stages, the two multiplier ranks and their adder stages before out_valid.
// Reset clears every valid bit and the control points (to zero).
// A full stage stalls only if all later stages are full; empty stages load,
// so bubbles close up and input is taken while a result waits at the output.
module cubic_bezier_point_and_derivatives
  import cbz_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TW-1:0]          in_param_t,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [CW-1:0]   out_point_x,
  output logic signed [CW-1:0]   out_point_y,
  output logic signed [SW-1:0]   out_slope_x,
  output logic signed [SW-1:0]   out_slope_y,
  output logic signed [BW-1:0]   out_bend_x,
  output logic signed [BW-1:0]   out_bend_y,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------
  // Control point registers
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] cp_r [NUM_REGS];
  logic                 cfg_wr;
  logic signed [CW-1:0] cfg_rd;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cp_r[i] <= '0;
    end else if (cfg_wr) begin
      cp_r[paddr[CFG_AW-1:2]] <= pwdata[CW-1:0];
    end
  end

  assign cfg_rd = cp_r[paddr[CFG_AW-1:2]];
  assign prdata = {{(CFG_DW-CW){cfg_rd[CW-1]}}, cfg_rd};

  // Control points per axis lane
  logic signed [CW-1:0] p0 [NUM_AX];
  logic signed [CW-1:0] p1 [NUM_AX];
  logic signed [CW-1:0] p2 [NUM_AX];
  logic signed [CW-1:0] p3 [NUM_AX];

  always_comb begin
    p0[AX_X] = cp_r[REG_START_X];
    p0[AX_Y] = cp_r[REG_START_Y];
    p1[AX_X] = cp_r[REG_PULL_A_X];
    p1[AX_Y] = cp_r[REG_PULL_A_Y];
    p2[AX_X] = cp_r[REG_PULL_B_X];
    p2[AX_Y] = cp_r[REG_PULL_B_Y];
    p3[AX_X] = cp_r[REG_END_X];
    p3[AX_Y] = cp_r[REG_END_Y];
  end

  // Differences between neighbouring control points
  logic signed [DW-1:0] dab [NUM_AX];  // p0 - p1
  logic signed [DW-1:0] d01 [NUM_AX];  // p1 - p0
  logic signed [DW-1:0] d12 [NUM_AX];  // p2 - p1
  logic signed [DW-1:0] m12 [NUM_AX];  // p1 - p2
  logic signed [DW-1:0] d23 [NUM_AX];  // p3 - p2

  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      dab[a] = DW'(p0[a]) - DW'(p1[a]);
      d01[a] = DW'(p1[a]) - DW'(p0[a]);
      d12[a] = DW'(p2[a]) - DW'(p1[a]);
      m12[a] = DW'(p1[a]) - DW'(p2[a]);
      d23[a] = DW'(p3[a]) - DW'(p2[a]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage advance: a stage loads when empty or when its successor loads
  // ---------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  assign adv6     = !v6_r || !out_stall;
  assign adv5     = !v5_r || adv6;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
      if (adv6) v6_r <= v5_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp t, form u = 1 - t
  // ---------------------------------------------------------------------
  logic [TW-1:0] t1_r, u1_r, t1_nxt;

  assign t1_nxt = (in_param_t > ONE_T) ? ONE_T : in_param_t;

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      t1_r <= t1_nxt;
      u1_r <= ONE_T - t1_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares of t and u
  // ---------------------------------------------------------------------
  logic [TW-1:0]   t2_r, u2_r, st2_r, su2_r;
  logic [2*TW-1:0] tt_nxt, uu_nxt;

  assign tt_nxt = t1_r * t1_r;
  assign uu_nxt = u1_r * u1_r;

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      t2_r  <= t1_r;
      u2_r  <= u1_r;
      st2_r <= tt_nxt[TW+FRAC_T-1:FRAC_T];
      su2_r <= uu_nxt[TW+FRAC_T-1:FRAC_T];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: first multiplier rank, differences scaled by t, u, t^2, u^2
  //   f0 (p0-p1)u^2  f1 (p2-p1)t^2  f2 (p1-p0)u  f3 (p2-p1)t
  //   f4 (p1-p2)u^2  f5 (p3-p2)t^2  f6 (p2-p1)u  f7 (p3-p2)t
  // ---------------------------------------------------------------------
  localparam int NF = 8;
  logic [TW-1:0]        t3_r, u3_r;
  logic signed [FW-1:0] f3_nxt [NUM_AX][NF];
  logic signed [FW-1:0] f3_r   [NUM_AX][NF];

  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      f3_nxt[a][0] = fmul_d(dab[a], su2_r);
      f3_nxt[a][1] = fmul_d(d12[a], st2_r);
      f3_nxt[a][2] = fmul_d(d01[a], u2_r);
      f3_nxt[a][3] = fmul_d(d12[a], t2_r);
      f3_nxt[a][4] = fmul_d(m12[a], su2_r);
      f3_nxt[a][5] = fmul_d(d23[a], st2_r);
      f3_nxt[a][6] = fmul_d(d12[a], u2_r);
      f3_nxt[a][7] = fmul_d(d23[a], t2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      t3_r <= t2_r;
      u3_r <= u2_r;
      for (int a = 0; a < NUM_AX; a++) begin
        for (int k = 0; k < NF; k++) f3_r[a][k] <= f3_nxt[a][k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: the two quadratics, their slopes and bends
  // ---------------------------------------------------------------------
  logic [TW-1:0]        t4_r, u4_r;
  logic signed [QW-1:0] q1_nxt [NUM_AX], d1_nxt [NUM_AX], s1_nxt [NUM_AX];
  logic signed [QW-1:0] q2_nxt [NUM_AX], d2_nxt [NUM_AX], s2_nxt [NUM_AX];
  logic signed [QW-1:0] q1_r [NUM_AX], d1_r [NUM_AX], s1_r [NUM_AX];
  logic signed [QW-1:0] q2_r [NUM_AX], d2_r [NUM_AX], s2_r [NUM_AX];

  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      q1_nxt[a] = QW'(p1[a]) + QW'(f3_r[a][0]) + QW'(f3_r[a][1]);
      d1_nxt[a] = (QW'(f3_r[a][2]) + QW'(f3_r[a][3])) <<< 1;
      s1_nxt[a] = (QW'(d12[a]) - QW'(d01[a])) <<< 1;
      q2_nxt[a] = QW'(p2[a]) + QW'(f3_r[a][4]) + QW'(f3_r[a][5]);
      d2_nxt[a] = (QW'(f3_r[a][6]) + QW'(f3_r[a][7])) <<< 1;
      s2_nxt[a] = (QW'(d23[a]) - QW'(d12[a])) <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3_r) begin
      t4_r <= t3_r;
      u4_r <= u3_r;
      for (int a = 0; a < NUM_AX; a++) begin
        q1_r[a] <= q1_nxt[a];
        d1_r[a] <= d1_nxt[a];
        s1_r[a] <= s1_nxt[a];
        q2_r[a] <= q2_nxt[a];
        d2_r[a] <= d2_nxt[a];
        s2_r[a] <= s2_nxt[a];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: second multiplier rank, blend by u and t
  // ---------------------------------------------------------------------
  logic signed [MW-1:0] mq1_r [NUM_AX], mq2_r [NUM_AX];
  logic signed [MW-1:0] md1_r [NUM_AX], md2_r [NUM_AX];
  logic signed [MW-1:0] ms1_r [NUM_AX], ms2_r [NUM_AX];
  logic signed [QW-1:0] q1b_r [NUM_AX], q2b_r [NUM_AX];
  logic signed [QW-1:0] d1b_r [NUM_AX], d2b_r [NUM_AX];

  always_ff @(posedge clk) begin
    if (adv5 && v4_r) begin
      for (int a = 0; a < NUM_AX; a++) begin
        mq1_r[a] <= fmul_q(q1_r[a], u4_r);
        mq2_r[a] <= fmul_q(q2_r[a], t4_r);
        md1_r[a] <= fmul_q(d1_r[a], u4_r);
        md2_r[a] <= fmul_q(d2_r[a], t4_r);
        ms1_r[a] <= fmul_q(s1_r[a], u4_r);
        ms2_r[a] <= fmul_q(s2_r[a], t4_r);
        q1b_r[a] <= q1_r[a];
        q2b_r[a] <= q2_r[a];
        d1b_r[a] <= d1_r[a];
        d2b_r[a] <= d2_r[a];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: final sums, saturate, output register
  // ---------------------------------------------------------------------
  logic signed [SUMW-1:0] pt_sum [NUM_AX], sl_sum [NUM_AX], bd_sum [NUM_AX];
  logic signed [CW-1:0]   pt_nxt [NUM_AX];
  logic signed [SW-1:0]   sl_nxt [NUM_AX];
  logic signed [BW-1:0]   bd_nxt [NUM_AX];
  logic signed [SUMW-1:0] pt_sat [NUM_AX], sl_sat [NUM_AX], bd_sat [NUM_AX];
  logic signed [CW-1:0]   pt6_r  [NUM_AX];
  logic signed [SW-1:0]   sl6_r  [NUM_AX];
  logic signed [BW-1:0]   bd6_r  [NUM_AX];

  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      pt_sum[a] = SUMW'(mq1_r[a]) + SUMW'(mq2_r[a]);
      sl_sum[a] = SUMW'(md1_r[a]) - SUMW'(q1b_r[a])
                + SUMW'(md2_r[a]) + SUMW'(q2b_r[a]);
      bd_sum[a] = SUMW'(ms1_r[a]) - (SUMW'(d1b_r[a]) <<< 1)
                + SUMW'(ms2_r[a]) + (SUMW'(d2b_r[a]) <<< 1);
      pt_sat[a] = sat(pt_sum[a], POINT_MIN, POINT_MAX);
      sl_sat[a] = sat(sl_sum[a], SLOPE_MIN, SLOPE_MAX);
      bd_sat[a] = sat(bd_sum[a], BEND_MIN, BEND_MAX);
      pt_nxt[a] = pt_sat[a][CW-1:0];
      sl_nxt[a] = sl_sat[a][SW-1:0];
      bd_nxt[a] = bd_sat[a][BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv6 && v5_r) begin
      for (int a = 0; a < NUM_AX; a++) begin
        pt6_r[a] <= pt_nxt[a];
        sl6_r[a] <= sl_nxt[a];
        bd6_r[a] <= bd_nxt[a];
      end
    end
  end

  assign out_valid   = v6_r;
  assign out_point_x = pt6_r[AX_X];
  assign out_point_y = pt6_r[AX_Y];
  assign out_slope_x = sl6_r[AX_X];
  assign out_slope_y = sl6_r[AX_Y];
  assign out_bend_x  = bd6_r[AX_X];
  assign out_bend_y  = bd6_r[AX_Y];

endmodule

>>> rtl/cbz_checker.sv
// Port-level checker for the cubic Bezier evaluator, bound to the top level.
// Depends on cbz_pkg and cubic_bezier_point_and_derivatives_assert.svh.
`include "cubic_bezier_point_and_derivatives_assert.svh"

module cbz_checker
  import cbz_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [CW-1:0] out_point_x,
  input logic signed [CW-1:0] out_point_y,
  input logic signed [SW-1:0] out_slope_x,
  input logic signed [SW-1:0] out_slope_y,
  input logic signed [BW-1:0] out_bend_x,
  input logic signed [BW-1:0] out_bend_y
);

  logic signed [SUMW-1:0]        slx, sly, bdx, bdy;
  logic [2*CW+2*SW+2*BW-1:0]     out_bus;
  logic                          slope_ok, bend_ok;

  assign slx = SUMW'(out_slope_x);
  assign sly = SUMW'(out_slope_y);
  assign bdx = SUMW'(out_bend_x);
  assign bdy = SUMW'(out_bend_y);

  // Gather the result payload for the hold check
  assign out_bus = {out_point_x, out_point_y, out_slope_x, out_slope_y,
                    out_bend_x, out_bend_y};

  // Range checks on the derivatives
  assign slope_ok = slx >= SLOPE_MIN && slx <= SLOPE_MAX &&
                    sly >= SLOPE_MIN && sly <= SLOPE_MAX;
  assign bend_ok  = bdx >= BEND_MIN && bdx <= BEND_MAX &&
                    bdy >= BEND_MIN && bdy <= BEND_MAX;

  // Hold a stalled result
  `CBZ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bus), "stall")

  // An empty output stage means the pipeline can take a transaction
  `CBZ_ASSERT_COMB(a_empty_takes, out_valid || !in_stall || !in_valid, "input stalled")

  // Slope stays inside its saturated range
  `CBZ_ASSERT_COMB(a_slope_range, !out_valid || slope_ok, "slope outside range")

  // Bend stays inside its saturated range
  `CBZ_ASSERT_COMB(a_bend_range, !out_valid || bend_ok, "bend outside range")

endmodule

bind cubic_bezier_point_and_derivatives cbz_checker u_cbz_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_point_x (out_point_x),
  .out_point_y (out_point_y),
  .out_slope_x (out_slope_x),
  .out_slope_y (out_slope_y),
  .out_bend_x  (out_bend_x),
  .out_bend_y  (out_bend_y)
);
